[hw/rtl/rbst_pkg.sv]
// rbst_pkg: shared constants for the ray/box slab test.
// Used by rbst_div_cell and ray_box_slab_test_core.
`default_nettype none
package rbst_pkg;
  localparam int AXES = 3;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/rbst_div_cell.sv]
// rbst_div_cell: one restoring-division step for the two slab quotients of all axes.
// Depends on rbst_pkg.
`default_nettype none
module rbst_div_cell #(
  parameter int NW = 34,
  parameter int QW = 18
) (
  input  wire logic                 clk,
  input  wire logic [NW-1:0]        n0_in [rbst_pkg::AXES],
  input  wire logic [NW-1:0]        n1_in [rbst_pkg::AXES],
  input  wire logic [NW-1:0]        d_in  [rbst_pkg::AXES],
  input  wire logic [QW-1:0]        q0_in [rbst_pkg::AXES],
  input  wire logic [QW-1:0]        q1_in [rbst_pkg::AXES],
  output logic      [NW-1:0]        n0_out [rbst_pkg::AXES],
  output logic      [NW-1:0]        n1_out [rbst_pkg::AXES],
  output logic      [NW-1:0]        d_out  [rbst_pkg::AXES],
  output logic      [QW-1:0]        q0_out [rbst_pkg::AXES],
  output logic      [QW-1:0]        q1_out [rbst_pkg::AXES]
);
  always_ff @(posedge clk) begin
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      d_out[a] <= d_in[a];
      if ({n0_in[a], 1'b0} >= {1'b0, d_in[a]}) begin
        n0_out[a] <= NW'({n0_in[a], 1'b0} - {1'b0, d_in[a]});
        q0_out[a] <= {q0_in[a][QW-2:0], 1'b1};
      end else begin
        n0_out[a] <= {n0_in[a][NW-2:0], 1'b0};
        q0_out[a] <= {q0_in[a][QW-2:0], 1'b0};
      end
      if ({n1_in[a], 1'b0} >= {1'b0, d_in[a]}) begin
        n1_out[a] <= NW'({n1_in[a], 1'b0} - {1'b0, d_in[a]});
        q1_out[a] <= {q1_in[a][QW-2:0], 1'b1};
      end else begin
        n1_out[a] <= {n1_in[a][NW-2:0], 1'b0};
        q1_out[a] <= {q1_in[a][QW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/rbst_axis_cell.sv]
// rbst_axis_cell: clips [near, far] by one axis's slab and passes it on.
`default_nettype none
module rbst_axis_cell #(
  parameter int TW = 20,
  parameter logic [1:0] AXIS = 2'd0
) (
  input  wire logic                 clk,
  input  wire logic                 skip,
  input  wire logic                 kill,
  input  wire logic                 swapped,
  input  wire logic signed [TW-1:0] t0,
  input  wire logic signed [TW-1:0] t1,
  input  wire logic                 miss_in,
  input  wire logic                 found_in,
  input  wire logic [1:0]           axis_in,
  input  wire logic                 pos_in,
  input  wire logic signed [TW-1:0] near_in,
  input  wire logic signed [TW-1:0] far_in,
  output logic                      miss_out,
  output logic                      found_out,
  output logic [1:0]                axis_out,
  output logic                      pos_out,
  output logic signed [TW-1:0]      near_out,
  output logic signed [TW-1:0]      far_out
);
  logic signed [TW-1:0] lo, hi, nn, ff;
  logic raise;
  always_comb begin
    lo = swapped ? t1 : t0;
    hi = swapped ? t0 : t1;
    raise = !skip && (lo > near_in);
    nn = raise ? lo : near_in;
    ff = (!skip && hi < far_in) ? hi : far_in;
  end
  always_ff @(posedge clk) begin
    miss_out  <= miss_in || kill || (ff < nn);
    found_out <= found_in || raise;
    axis_out  <= raise ? AXIS : axis_in;
    pos_out   <= raise ? swapped : pos_in;
    near_out  <= nn;
    far_out   <= ff;
  end
endmodule
`default_nettype wire

[hw/rtl/ray_box_slab_test_core.sv]
// ray_box_slab_test_core: pipelined segment vs. box slab test.
// Depends on rbst_pkg, rbst_div_cell, rbst_axis_cell.
//
//  channel | handshake           | payload
//  request | start / busy        | start_*, end_*, max_fraction
//  result  | done (one cycle)    | hit, hit_fraction, normal_axis, normal_positive
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
// A request is taken every cycle (busy stays low). done rises after the
// accepting edge has passed the setup stage, the chain of one-bit divider
// cells, three axis cells and the output register. Reset clears the pipe valid
// bits and returns the configuration to its reset values. The receiver
// cannot stall.
`default_nettype none
module ray_box_slab_test_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] start_z,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [COORD_BITS-1:0] end_z,
  input  wire logic [FRAC_BITS:0]    max_fraction,
  output logic                       done,
  output logic                       hit,
  output logic [FRAC_BITS:0]         hit_fraction,
  output logic [1:0]                 normal_axis,
  output logic                       normal_positive,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [30:0]           cfg_data
);
  localparam int AX = rbst_pkg::AXES;
  localparam int XW = ((COORD_BITS > 31) ? COORD_BITS : 31) + 2; // setup arithmetic
  localparam int NW = XW;               // numerator/denominator magnitude
  localparam int QW = FRAC_BITS + 2;    // quotient up to 2.0
  localparam int TW = FRAC_BITS + 4;    // signed fraction
  localparam int DEPTH = FRAC_BITS + 1; // divider chain nodes, one more than the cells
  localparam logic [1:0] IDX_HX = 2'd0;
  localparam logic [1:0] IDX_HY = 2'd1;
  localparam logic [1:0] IDX_HZ = 2'd2;
  localparam logic [1:0] IDX_TH = 2'd3;

  logic [30:0] half [AX];
  logic [15:0] thresh;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AX; a++) half[a] <= 31'd65536;
      thresh <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        IDX_HX: half[0] <= cfg_data;
        IDX_HY: half[1] <= cfg_data;
        IDX_HZ: half[2] <= cfg_data;
        IDX_TH: thresh <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---- stage 0: setup
  logic signed [COORD_BITS-1:0] sp [AX];
  logic signed [COORD_BITS-1:0] ep [AX];
  always_comb begin
    sp[0] = start_x; sp[1] = start_y; sp[2] = start_z;
    ep[0] = end_x;   ep[1] = end_y;   ep[2] = end_z;
  end

  typedef struct packed {
    logic             vld;
    logic             early_miss;
    logic [AX-1:0]    skip;
    logic [AX-1:0]    kill;
    logic [AX-1:0]    swp;
    logic [AX-1:0]    neg0;
    logic [AX-1:0]    neg1;
    logic [AX-1:0]    sat0;
    logic [AX-1:0]    sat1;
    logic [FRAC_BITS:0] maxf;
  } side_t;

  side_t s0;
  logic [NW-1:0] n0_s [AX], n1_s [AX], d_s [AX];
  logic [QW-1:0] q_zero [AX];
  logic [QW-1:0] q1_init [AX];

  always_ff @(posedge clk) begin
    logic signed [XW-1:0] dd, hh, pp, a0, a1;
    logic [NW-1:0] dm, m0, m1;
    logic outside, ins;
    if (rst) s0.vld <= 1'b0;
    else s0.vld <= start;
    ins = 1'b1;
    for (int a = 0; a < AX; a++) begin
      pp = XW'(sp[a]);
      hh = XW'($signed({1'b0, half[a]}));
      dd = XW'(ep[a]) - pp;
      a0 = -hh - pp;
      a1 = hh - pp;
      dm = NW'(dd < 0 ? -dd : dd);
      m0 = NW'(a0 < 0 ? -a0 : a0);
      m1 = NW'(a1 < 0 ? -a1 : a1);
      outside = (pp < -hh) || (pp > hh);
      if (outside) ins = 1'b0;
      s0.skip[a] <= dm <= NW'(thresh);
      s0.kill[a] <= (dm <= NW'(thresh)) && outside;
      s0.swp[a]  <= (dd < 0) && (half[a] != 31'd0);
      s0.neg0[a] <= (a0 < 0) != (dd < 0);
      s0.neg1[a] <= (a1 < 0) != (dd < 0);
      s0.sat0[a] <= {1'b0, m0} >= {dm, 1'b0};
      s0.sat1[a] <= {1'b0, m1} >= {dm, 1'b0};
      d_s[a] <= dm;
      if (m0 >= dm) n0_s[a] <= m0 - dm; else n0_s[a] <= m0;
      if (m1 >= dm) n1_s[a] <= m1 - dm; else n1_s[a] <= m1;
      q_zero[a] <= {{(QW-1){1'b0}}, m0 >= dm};
      q1_init[a] <= {{(QW-1){1'b0}}, m1 >= dm};
    end
    s0.early_miss <= ins;
    s0.maxf <= (max_fraction > (FRAC_BITS+1)'(1 << FRAC_BITS))
               ? (FRAC_BITS+1)'(1 << FRAC_BITS) : max_fraction;
  end

  // ---- divider chain
  logic [NW-1:0] n0c [DEPTH][AX], n1c [DEPTH][AX], dc [DEPTH][AX];
  logic [QW-1:0] q0c [DEPTH][AX], q1c [DEPTH][AX];
  side_t sc [DEPTH];
  assign n0c[0] = n0_s; assign n1c[0] = n1_s; assign dc[0] = d_s;
  assign q0c[0] = q_zero; assign q1c[0] = q1_init;
  assign sc[0] = s0;

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
    rbst_div_cell #(.NW(NW), .QW(QW)) u_cell (
      .clk(clk),
      .n0_in(n0c[g]), .n1_in(n1c[g]), .d_in(dc[g]),
      .q0_in(q0c[g]), .q1_in(q1c[g]),
      .n0_out(n0c[g+1]), .n1_out(n1c[g+1]), .d_out(dc[g+1]),
      .q0_out(q0c[g+1]), .q1_out(q1c[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) sc[g+1].vld <= 1'b0;
      else sc[g+1].vld <= sc[g].vld;
      sc[g+1][$bits(side_t)-2:0] <= sc[g][$bits(side_t)-2:0];
    end
  end

  // ---- signed quotients
  localparam int L = DEPTH - 1;
  logic signed [TW-1:0] t0 [AX], t1 [AX];
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      logic [QW-1:0] m0, m1;
      m0 = sc[L].sat0[a] ? QW'(2 << FRAC_BITS) : q0c[L][a];
      m1 = sc[L].sat1[a] ? QW'(2 << FRAC_BITS) : q1c[L][a];
      t0[a] = sc[L].neg0[a] ? -TW'(m0) : TW'(m0);
      t1[a] = sc[L].neg1[a] ? -TW'(m1) : TW'(m1);
    end
  end

  // ---- axis chain; quotients delayed to line up
  logic signed [TW-1:0] t0d [AX][AX], t1d [AX][AX];
  side_t sa [AX+1];
  logic miss_c [AX+1], found_c [AX+1], pos_c [AX+1];
  logic [1:0] axis_c [AX+1];
  logic signed [TW-1:0] near_c [AX+1], far_c [AX+1];
  assign sa[0] = sc[L];
  assign miss_c[0] = sc[L].early_miss;
  assign found_c[0] = 1'b0;
  assign pos_c[0] = 1'b0;
  assign axis_c[0] = rbst_pkg::AXIS_X;
  assign near_c[0] = '0;
  assign far_c[0] = TW'(sc[L].maxf);
  for (genvar a = 0; a < AX; a++) begin : g_tl
    assign t0d[a][0] = t0[a];
    assign t1d[a][0] = t1[a];
    for (genvar k = 1; k < AX; k++) begin : g_dl
      always_ff @(posedge clk) begin
        t0d[a][k] <= t0d[a][k-1];
        t1d[a][k] <= t1d[a][k-1];
      end
    end
  end

  for (genvar a = 0; a < AX; a++) begin : g_ax
    rbst_axis_cell #(.TW(TW), .AXIS(2'(a))) u_ax (
      .clk(clk),
      .skip(sa[a].skip[a]), .kill(sa[a].kill[a]), .swapped(sa[a].swp[a]),
      .t0(t0d[a][a]), .t1(t1d[a][a]),
      .miss_in(miss_c[a]), .found_in(found_c[a]), .axis_in(axis_c[a]),
      .pos_in(pos_c[a]), .near_in(near_c[a]), .far_in(far_c[a]),
      .miss_out(miss_c[a+1]), .found_out(found_c[a+1]), .axis_out(axis_c[a+1]),
      .pos_out(pos_c[a+1]), .near_out(near_c[a+1]), .far_out(far_c[a+1])
    );
    always_ff @(posedge clk) begin
      if (rst) sa[a+1].vld <= 1'b0;
      else sa[a+1].vld <= sa[a].vld;
      sa[a+1][$bits(side_t)-2:0] <= sa[a][$bits(side_t)-2:0];
    end
  end

  // ---- output register
  logic ok;
  assign ok = !miss_c[AX] && found_c[AX] && near_c[AX] >= 0
              && near_c[AX] <= TW'(sa[AX].maxf);
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sa[AX].vld;
    hit <= ok;
    hit_fraction <= ok ? near_c[AX][FRAC_BITS:0] : '0;
    normal_axis <= ok ? axis_c[AX] : rbst_pkg::AXIS_X;
    normal_positive <= ok && pos_c[AX];
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> hit_fraction == '0 && normal_axis == rbst_pkg::AXIS_X
    && !normal_positive) else $error("miss payload not cleared");
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> normal_axis <= rbst_pkg::AXIS_Z) else $error("bad normal axis");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> hit_fraction <= (FRAC_BITS+1)'(1 << FRAC_BITS))
    else $error("hit fraction above one");
endmodule
`default_nettype wire

[dv/ray_box_slab_test_core_test.sv]
// Self-checking testbench for ray_box_slab_test_core: segment vs. box slab test.
// Random and directed segments are checked against an in-bench slab predictor.
// Depends on rbst_pkg and the ray_box_slab_test_core RTL.
`timescale 1ns / 100ps
module ray_box_slab_test_core_test;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int LATENCY = FB + 5;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam logic [1:0] REG_HALF_X = 2'd0;
  localparam logic [1:0] REG_HALF_Y = 2'd1;
  localparam logic [1:0] REG_HALF_Z = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] sx, sy, sz, ex, ey, ez;
    logic [FB:0] maxf;
  } seg_t;

  typedef struct packed {
    logic hit;
    logic [FB:0] frac;
    logic [1:0] axis;
    logic pos;
  } isect_t;

  logic clk = 0, rst = 1;
  logic start = 0;
  logic busy, done, hit, normal_positive, cfg_ready;
  logic [CB-1:0] start_x = 0, start_y = 0, start_z = 0, end_x = 0, end_y = 0, end_z = 0;
  logic [FB:0] max_fraction = 0, hit_fraction;
  logic [1:0] normal_axis;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = 0;
  logic [30:0] cfg_data = 0;

  ray_box_slab_test_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z), .max_fraction(max_fraction),
    .done(done), .hit(hit), .hit_fraction(hit_fraction), .normal_axis(normal_axis),
    .normal_positive(normal_positive), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  longint half_ext[3];
  longint par_thresh;
  seg_t pending_segs[$];
  isect_t expected_isects[$];
  int errors = 0, cycles = 0, n_checked = 0, n_hits = 0;
  bit quiet_mode = 0;

  function automatic longint slab_div(longint num, longint den);
    longint n, d, q;
    bit neg;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    if (n >= 2 * d) begin
      q = 2 * ONE;
    end else begin
      q = n / d;
      n = n - q * d;
      for (int i = 0; i < FB; i++) begin
        n = n <<< 1;
        q = q <<< 1;
        if (n >= d) begin
          n = n - d;
          q = q | 1;
        end
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic isect_t predict_isect(seg_t sg);
    longint s[3], d[3], h[3];
    longint maxf, near_t, far_t, t0, t1, tmp, mag;
    int axis;
    bit pos, in_box, sw;
    isect_t r;
    s[0] = longint'(signed'(sg.sx));
    s[1] = longint'(signed'(sg.sy));
    s[2] = longint'(signed'(sg.sz));
    d[0] = longint'(signed'(sg.ex)) - s[0];
    d[1] = longint'(signed'(sg.ey)) - s[1];
    d[2] = longint'(signed'(sg.ez)) - s[2];
    in_box = 1;
    for (int i = 0; i < 3; i++) begin
      h[i] = half_ext[i];
      if (s[i] < -h[i] || s[i] > h[i]) in_box = 0;
    end
    maxf = longint'(sg.maxf);
    if (maxf > ONE) maxf = ONE;
    r = '0;
    if (in_box) return r;
    near_t = 0;
    far_t = maxf;
    axis = -1;
    pos = 0;
    for (int i = 0; i < 3; i++) begin
      mag = d[i] < 0 ? -d[i] : d[i];
      if (mag <= par_thresh) begin
        if (s[i] < -h[i] || s[i] > h[i]) return r;
        continue;
      end
      t0 = slab_div(-h[i] - s[i], d[i]);
      t1 = slab_div(h[i] - s[i], d[i]);
      sw = d[i] < 0 && h[i] > 0;
      if (sw) begin
        tmp = t0;
        t0 = t1;
        t1 = tmp;
      end
      if (t0 > near_t) begin
        near_t = t0;
        axis = i;
        pos = sw;
      end
      if (t1 < far_t) far_t = t1;
      if (far_t < near_t) return r;
    end
    if (axis < 0 || near_t < 0 || near_t > maxf) return r;
    r.hit = 1;
    r.frac = near_t[FB:0];
    r.axis = axis[1:0];
    r.pos = pos;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch #%0d %s: got %0d expected %0d (t=%0t)", errors, what, got, want, $time);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_isects.push_back(predict_isect(
          {start_x, start_y, start_z, end_x, end_y, end_z, max_fraction}));
        void'(pending_segs.pop_front());
      end
      if (pending_segs.size() > 0 &&
          (quiet_mode || $urandom_range(99) >= 18)) begin
        seg_t nx;
        nx = pending_segs[0];
        start <= 1;
        {start_x, start_y, start_z, end_x, end_y, end_z, max_fraction} <= nx;
      end else if (!(start && busy)) begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_isects.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        isect_t e;
        e = expected_isects.pop_front();
        if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
        if (hit_fraction !== e.frac) report_mismatch("hit_fraction", hit_fraction, e.frac);
        if (normal_axis !== e.axis) report_mismatch("normal_axis", normal_axis, e.axis);
        if (normal_positive !== e.pos)
          report_mismatch("normal_positive", normal_positive, e.pos);
        n_checked++;
        if (e.hit) n_hits++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ray_box_slab_test_core_test NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_HALF_X: half_ext[0] = val;
      REG_HALF_Y: half_ext[1] = val;
      REG_HALF_Z: half_ext[2] = val;
      REG_THRESH: par_thresh = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_segs.size() != 0 || start || expected_isects.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord(longint h);
    longint r;
    case ($urandom_range(5))
      0: return $urandom;
      1: return (h > 0) ? CB'(longint'($urandom_range(2)) * h - h) : 0;
      default: begin
        r = longint'($urandom_range(6 * 65536)) - 3 * 65536;
        if (h > 65536 * 4) r = r * (h / 65536);
        return CB'(r);
      end
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t sg;
    sg.sx = rand_coord(half_ext[0]);
    sg.sy = rand_coord(half_ext[1]);
    sg.sz = rand_coord(half_ext[2]);
    sg.ex = rand_coord(half_ext[0]);
    sg.ey = rand_coord(half_ext[1]);
    sg.ez = rand_coord(half_ext[2]);
    // occasionally make an axis parallel or near-parallel
    if ($urandom_range(7) == 0) sg.ex = sg.sx + ($urandom_range(4) - 2);
    if ($urandom_range(7) == 0) sg.ey = sg.sy + ($urandom_range(4) - 2);
    if ($urandom_range(9) == 0) sg.ez = sg.sz + $urandom_range(70000);
    case ($urandom_range(4))
      0: sg.maxf = (FB+1)'($urandom);
      1: sg.maxf = 17'h10000;
      default: sg.maxf = (FB+1)'($urandom_range(65536, 20000));
    endcase
    return sg;
  endfunction

  localparam logic [CB-1:0] C_MIN = 32'h8000_0000;
  localparam logic [CB-1:0] C_MAX = 32'h7fff_ffff;
  localparam logic [CB-1:0] C_P2 = 32'h0002_0000;
  localparam logic [CB-1:0] C_M2 = 32'hfffe_0000;

  initial begin
    half_ext[0] = 65536;
    half_ext[1] = 65536;
    half_ext[2] = 65536;
    par_thresh = 1;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: inside start, entries on each axis and sign, parallel, swap,
    // empty interval, extremes of fields, max fraction above one
    pending_segs.push_back({32'h0, 32'h0, 32'h0, C_P2, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_M2, 32'h0, 32'h0, C_P2, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_P2, 32'h0, 32'h0, C_M2, 32'h0, 32'h0, 17'h1ffff});
    pending_segs.push_back({32'h0, C_M2, 32'h0, 32'h0, C_P2, 32'h0, 17'h10000});
    pending_segs.push_back({32'h0, C_P2, 32'h0, 32'h0, C_M2, 32'h0, 17'h10000});
    pending_segs.push_back({32'h0, 32'h0, C_M2, 32'h0, 32'h0, C_P2, 17'h10000});
    pending_segs.push_back({32'h0, 32'h0, C_P2, 32'h0, 32'h0, C_M2, 17'h08000});
    pending_segs.push_back({C_M2, C_P2, 32'h0, C_P2, C_P2, 32'h0, 17'h10000});
    pending_segs.push_back({C_M2, 32'h0, 32'h0, C_M2 + 1, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_M2, C_M2, 32'h0, C_P2, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 17'h1ffff});
    pending_segs.push_back({C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 17'h10000});
    pending_segs.push_back({C_M2, 32'h0, 32'h0, C_P2, 32'h0, 32'h0, 17'h0});
    pending_segs.push_back({C_M2, 32'h0, 32'h0, 32'hffff_0000, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_MIN, 32'h0, 32'h0, C_MIN, 32'h0, 32'h0, 17'h10000});
    pending_segs.push_back({C_M2, C_M2, C_M2, C_P2, C_P2, C_P2, 17'h10000});
    drain();

    // phases of configuration, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_HALF_X, 31'h0);
          write_reg(REG_HALF_Y, 31'h0);
          write_reg(REG_HALF_Z, 31'h0);
          write_reg(REG_THRESH, 31'h0);
        end
        1: begin
          write_reg(REG_HALF_X, 31'h7fff_ffff);
          write_reg(REG_HALF_Y, 31'h0003_0000);
          write_reg(REG_HALF_Z, 31'h0000_8000);
          write_reg(REG_THRESH, 31'hffff);
        end
        5: begin
          write_reg(REG_HALF_X, 31'h10000);
          write_reg(REG_HALF_Y, 31'h10000);
          write_reg(REG_HALF_Z, 31'h10000);
          write_reg(REG_THRESH, 31'h1);
        end
        default: begin
          write_reg(REG_HALF_X, 31'($urandom_range(4 * 65536)));
          write_reg(REG_HALF_Y, 31'($urandom_range(4 * 65536)));
          write_reg(REG_HALF_Z, (ph == 4) ? 31'($urandom) : 31'($urandom_range(4 * 65536)));
          write_reg(REG_THRESH, 31'($urandom_range(65535)));
        end
      endcase
      quiet_mode = (ph == 2);
      for (int k = 0; k < 250; k++) pending_segs.push_back(rand_seg());
      drain();
    end

    $display("checked %0d segment results (%0d hits) across 7 box and threshold settings",
             n_checked, n_hits);
    if (errors == 0) begin
      $display("ray_box_slab_test_core_test OK");
    end else begin
      $display("ray_box_slab_test_core_test NOT OK");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div_cell.sv
hw/rtl/rbst_axis_cell.sv
hw/rtl/ray_box_slab_test_core.sv
dv/ray_box_slab_test_core_test.sv
